// ===== rtl/zcep_pkg.sv =====
package zcep_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int TABLE_BITS     = 10;
	localparam int CHANNELS       = 2;
	localparam int TABLE_SIZE     = 1 << TABLE_BITS;
	localparam int GAIN_BITS      = 16;
	localparam int GAIN_FRAC      = 15;
	localparam int FRAME_BITS     = 24;
	localparam int PHASE_BITS     = 32;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 32;
	localparam int IN_DATA_BITS   = 2 * CHANNELS * SAMPLE_BITS;
	localparam int OUT_DATA_BITS  = CHANNELS * SAMPLE_BITS;

	localparam logic [GAIN_BITS-1:0]  Q15_ONE      = GAIN_BITS'(1 << GAIN_FRAC);
	localparam logic [FRAME_BITS-1:0] TOTAL_RESET  = FRAME_BITS'(120000);
	localparam logic [PHASE_BITS-1:0] STEP_RESET   = PHASE_BITS'(35791);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TOTAL_FRAMES = 2'd0,
		REG_PHASE_STEP   = 2'd1
	} cfg_reg_t;

	// Frame handed from the gain stage to the mix stage
	typedef struct packed {
		logic                                    valid;
		logic                                    pass;
		logic                                    done;
		logic [CHANNELS-1:0][SAMPLE_BITS-1:0]    from_smp;
		logic [CHANNELS-1:0][SAMPLE_BITS-1:0]    to_smp;
		logic [CHANNELS-1:0][GAIN_BITS-1:0]      gain_out;
		logic [CHANNELS-1:0][GAIN_BITS-1:0]      gain_in;
	} zcep_stage_t;

	typedef logic [GAIN_BITS-1:0] gain_rom_t [TABLE_SIZE];

	// Q30 coefficients of cos(pi/2*u) in powers of u^2, alternating signs
	localparam logic [63:0] COS_COEF [8] = '{
		64'd1073741824, 64'd1324675879, 64'd272375562, 64'd22402022,
		64'd987047, 64'd27060, 64'd506, 64'd7
	};

	function automatic logic [GAIN_BITS-1:0] gain_entry(input int unsigned k);
		logic [63:0] u;
		logic [63:0] x;
		logic [63:0] r;
		logic [63:0] t;
		logic [63:0] g;
		u = 64'(2 * k + 1) << (29 - TABLE_BITS);
		x = (u * u) >> 30;
		r = COS_COEF[7];
		for (int i = 6; i >= 0; i--) begin
			t = (r * x) >> 30;
			r = (COS_COEF[i] > t) ? COS_COEF[i] - t : 64'd0;
		end
		g = (r * r + (64'd1 << 44)) >> 45;
		if (g > 64'(Q15_ONE)) begin
			g = 64'(Q15_ONE);
		end
		return g[GAIN_BITS-1:0];
	endfunction

	function automatic gain_rom_t build_gain_rom();
		gain_rom_t rom;
		for (int k = 0; k < TABLE_SIZE; k++) begin
			rom[k] = gain_entry(k);
		end
		return rom;
	endfunction

endpackage

// ===== rtl/zcep_gain_rom.sv =====
module zcep_gain_rom
	import zcep_pkg::*;
(
	input  logic                  clk,
	input  logic [TABLE_BITS-1:0] addr_a,
	input  logic [TABLE_BITS-1:0] addr_b,
	output logic [GAIN_BITS-1:0]  data_a,
	output logic [GAIN_BITS-1:0]  data_b
);

	localparam gain_rom_t ROM = build_gain_rom();

	logic [GAIN_BITS-1:0] data_a_q;
	logic [GAIN_BITS-1:0] data_b_q;

	always_ff @(posedge clk) begin
		data_a_q <= ROM[addr_a];
		data_b_q <= ROM[addr_b];
	end

	assign data_a = data_a_q;
	assign data_b = data_b_q;

endmodule

// ===== rtl/zcep_ctrl.sv =====
module zcep_ctrl
	import zcep_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [IN_DATA_BITS-1:0]   s_tdata,
	input  logic                      s_tuser,
	input  logic                      cfg_valid,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output logic [TABLE_BITS-1:0]     rom_addr_a,
	output logic [TABLE_BITS-1:0]     rom_addr_b,
	input  logic [GAIN_BITS-1:0]      rom_data_a,
	input  logic [GAIN_BITS-1:0]      rom_data_b,
	input  logic                      mix_ready,
	output zcep_stage_t               stage
);

	logic [FRAME_BITS-1:0] total_q;
	logic [PHASE_BITS-1:0] step_q;
	logic [FRAME_BITS-1:0] pos_q;
	logic [PHASE_BITS-1:0] phase_q;
	logic [GAIN_BITS-1:0]  gain_out_q [CHANNELS];
	logic [GAIN_BITS-1:0]  gain_in_q  [CHANNELS];
	logic [CHANNELS-1:0]   sign_from_q;
	logic [CHANNELS-1:0]   sign_to_q;
	logic                  signs_valid_q;
	logic                  finished_q;
	logic                  primed_q;
	zcep_stage_t           stage_s1;

	logic                  accept;
	logic                  start;
	logic                  fin_eff;
	logic                  last;
	logic                  s1_adv;
	logic [FRAME_BITS-1:0] pos_eff;
	logic [PHASE_BITS-1:0] phase_eff;
	logic [PHASE_BITS:0]   phase_sum;
	logic [PHASE_BITS-1:0] phase_inc;
	logic [PHASE_BITS-1:0] phase_nxt;
	logic [PHASE_BITS-1:0] step_nxt;
	logic [GAIN_BITS-1:0]  nout;
	logic [GAIN_BITS-1:0]  nin;
	logic [GAIN_BITS-1:0]  go_n [CHANNELS];
	logic [GAIN_BITS-1:0]  gi_n [CHANNELS];
	logic [CHANNELS-1:0]   sf;
	logic [CHANNELS-1:0]   st;
	logic                  wr_step;

	function automatic logic [TABLE_BITS-1:0] table_index(
		input logic [PHASE_BITS-1:0] phase,
		input logic [PHASE_BITS-1:0] step
	);
		logic [PHASE_BITS:0] ph;
		ph = {1'b0, phase} + {2'b00, step[PHASE_BITS-1:1]};
		return ph[PHASE_BITS] ? '1 : ph[PHASE_BITS-1 -: TABLE_BITS];
	endfunction

	assign start    = s_tuser;
	assign s1_adv   = !stage_s1.valid || mix_ready;
	assign s_tready = primed_q && s1_adv;
	assign accept   = s_tvalid && s_tready;
	assign fin_eff  = finished_q && !start;
	assign pos_eff   = start ? '0 : pos_q;
	assign phase_eff = start ? '0 : phase_q;
	assign last = ({1'b0, pos_eff} + (FRAME_BITS + 1)'(1)) >= {1'b0, total_q};
	assign phase_sum = {1'b0, phase_eff} + {1'b0, step_q};
	assign phase_inc = phase_sum[PHASE_BITS] ? '1 : phase_sum[PHASE_BITS-1:0];
	assign nout = start ? rom_data_b : rom_data_a;
	assign nin  = Q15_ONE - nout;

	always_comb begin
		wr_step = 1'b0;
		if (cfg_valid) begin
			unique case (cfg_index)
				REG_PHASE_STEP: wr_step = 1'b1;
				default:        wr_step = 1'b0;
			endcase
		end
	end

	assign step_nxt  = wr_step ? cfg_data : step_q;
	assign phase_nxt = (accept && !fin_eff) ? (last ? phase_eff : phase_inc) : phase_q;

	// Keep the ROM outputs tracking the state after this edge: port A for the
	// running transition, port B for a transition that restarts
	assign rom_addr_a = table_index(phase_nxt, step_nxt);
	assign rom_addr_b = table_index('0, step_nxt);

	always_comb begin
		logic [GAIN_BITS-1:0] go_e;
		logic [GAIN_BITS-1:0] gi_e;
		logic                 lsf;
		logic                 lst;
		logic                 sv_e;
		sv_e = signs_valid_q && !start;
		for (int j = 0; j < CHANNELS; j++) begin
			sf[j] = !s_tdata[j*SAMPLE_BITS + SAMPLE_BITS - 1];
			st[j] = !s_tdata[(CHANNELS+j)*SAMPLE_BITS + SAMPLE_BITS - 1];
			go_e  = start ? '0 : gain_out_q[j];
			gi_e  = start ? '0 : gain_in_q[j];
			lsf   = sv_e ? sign_from_q[j] : sf[j];
			lst   = sv_e ? sign_to_q[j] : st[j];
			go_n[j] = (go_e == '0) ? nout : go_e;
			gi_n[j] = (go_e == '0) ? nin : gi_e;
			if (sf[j] != lsf) begin
				go_n[j] = nout;
			end
			if (st[j] != lst) begin
				gi_n[j] = nin;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q       <= TOTAL_RESET;
			step_q        <= STEP_RESET;
			pos_q         <= '0;
			phase_q       <= '0;
			sign_from_q   <= '0;
			sign_to_q     <= '0;
			signs_valid_q <= 1'b0;
			finished_q    <= 1'b0;
			primed_q      <= 1'b0;
			for (int j = 0; j < CHANNELS; j++) begin
				gain_out_q[j] <= '0;
				gain_in_q[j]  <= '0;
			end
		end else begin
			primed_q <= 1'b1;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_TOTAL_FRAMES: total_q <= cfg_data[FRAME_BITS-1:0];
					REG_PHASE_STEP:   step_q  <= cfg_data[PHASE_BITS-1:0];
					default: ;
				endcase
			end
			if (accept && !fin_eff) begin
				for (int j = 0; j < CHANNELS; j++) begin
					gain_out_q[j] <= go_n[j];
					gain_in_q[j]  <= gi_n[j];
				end
				sign_from_q   <= sf;
				sign_to_q     <= st;
				signs_valid_q <= 1'b1;
				phase_q       <= phase_nxt;
				if (last) begin
					finished_q <= 1'b1;
					pos_q      <= pos_eff;
				end else begin
					finished_q <= 1'b0;
					pos_q      <= pos_eff + FRAME_BITS'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else begin
			if (s1_adv) begin
				stage_s1.valid <= accept;
			end
			if (accept) begin
				stage_s1.pass     <= fin_eff;
				stage_s1.done     <= !fin_eff && last;
				stage_s1.from_smp <= s_tdata[CHANNELS*SAMPLE_BITS-1:0];
				stage_s1.to_smp   <= s_tdata[IN_DATA_BITS-1:CHANNELS*SAMPLE_BITS];
				for (int j = 0; j < CHANNELS; j++) begin
					stage_s1.gain_out[j] <= go_n[j];
					stage_s1.gain_in[j]  <= gi_n[j];
				end
			end
		end
	end

	assign stage = stage_s1;

	a_primed: assert property (@(posedge clk) disable iff (!arst_n)
		!primed_q |-> !s_tready)
		else $error("input taken before the gain ROM output was valid");

	a_phase_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && start) |=> phase_q >= $past(phase_q))
		else $error("phase accumulator went backwards without a restart");

	a_finished_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(finished_q && !(accept && start)) |=> finished_q && $stable(pos_q))
		else $error("finished transition changed state without a restart");

endmodule

// ===== rtl/zcep_mix.sv =====
module zcep_mix
	import zcep_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  zcep_stage_t              stage,
	output logic                     mix_ready,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	output logic                     m_tlast,
	output logic                     m_tuser
);

	localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
	localparam int ACC_BITS  = PROD_BITS + 1;
	localparam int Q_BITS    = ACC_BITS - GAIN_FRAC;
	localparam logic signed [ACC_BITS-1:0] ROUND_BIAS =
		ACC_BITS'((64'd1 << GAIN_FRAC) - 64'd1);
	localparam logic signed [Q_BITS-1:0] QMAX =
		Q_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [Q_BITS-1:0] QMIN = ~QMAX;
	localparam logic [SAMPLE_BITS-1:0] SMAX = QMAX[SAMPLE_BITS-1:0];
	localparam logic [SAMPLE_BITS-1:0] SMIN = QMIN[SAMPLE_BITS-1:0];

	logic                     valid_q;
	logic [OUT_DATA_BITS-1:0] data_q;
	logic                     last_q;
	logic                     clip_q;

	logic [OUT_DATA_BITS-1:0] mix_data;
	logic                     mix_clip;

	assign mix_ready = !valid_q || m_tready;

	always_comb begin
		logic signed [PROD_BITS-1:0] pf;
		logic signed [PROD_BITS-1:0] pt;
		logic signed [ACC_BITS-1:0]  acc;
		logic signed [ACC_BITS-1:0]  biased;
		logic signed [Q_BITS-1:0]    q;
		mix_clip = 1'b0;
		mix_data = '0;
		for (int j = 0; j < CHANNELS; j++) begin
			pf = PROD_BITS'($signed(stage.from_smp[j]))
				* PROD_BITS'($signed({1'b0, stage.gain_out[j]}));
			pt = PROD_BITS'($signed(stage.to_smp[j]))
				* PROD_BITS'($signed({1'b0, stage.gain_in[j]}));
			acc = ACC_BITS'(pf) + ACC_BITS'(pt);
			// bias negatives so the shift truncates toward zero
			biased = acc + (acc[ACC_BITS-1] ? ROUND_BIAS : '0);
			q = $signed(biased[ACC_BITS-1:GAIN_FRAC]);
			if (q > QMAX) begin
				mix_data[j*SAMPLE_BITS +: SAMPLE_BITS] = SMAX;
				mix_clip = 1'b1;
			end else if (q < QMIN) begin
				mix_data[j*SAMPLE_BITS +: SAMPLE_BITS] = SMIN;
				mix_clip = 1'b1;
			end else begin
				mix_data[j*SAMPLE_BITS +: SAMPLE_BITS] = q[SAMPLE_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (mix_ready) begin
			valid_q <= stage.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (mix_ready && stage.valid) begin
			if (stage.pass) begin
				data_q <= stage.to_smp;
				last_q <= 1'b0;
				clip_q <= 1'b0;
			end else begin
				data_q <= mix_data;
				last_q <= stage.done;
				clip_q <= mix_clip;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tlast  = last_q;
	assign m_tuser  = clip_q;

	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && clip_q) |->
			(data_q[SAMPLE_BITS-1:0] == SMAX || data_q[SAMPLE_BITS-1:0] == SMIN ||
			 data_q[OUT_DATA_BITS-1 -: SAMPLE_BITS] == SMAX ||
			 data_q[OUT_DATA_BITS-1 -: SAMPLE_BITS] == SMIN))
		else $error("clip flag set with neither channel on a rail");

endmodule

// ===== rtl/zero_cross_equal_power_crossfade_core.sv =====
// Equal-power crossfade between an outgoing and an incoming stereo track.
//
// Input stream (s_axis): one transaction per frame. tdata carries the
// outgoing left/right and incoming left/right samples; tuser set marks the
// first frame of a new transition and restarts position, phase and gains.
// Output stream (m_axis): one transaction per input frame, in order. tlast
// flags the last frame of the transition, tuser flags saturation.
// Configuration (cfg_*): length in frames and per-frame phase step; write
// only while the stream is idle. cfg_ready is always high.
//
// Throughput is one frame per cycle while the receiver keeps up. The gain stage
// registers the chosen gains, then the mix stage registers the saturated sums.
// The gain ROM is registered and read ahead, with addresses taken from the
// phase state that the current edge leaves behind.
//
// After reset s_axis_tready stays low while the ROM output loads.
// When the receiver stalls, the output register holds its frame,
// the gain stage fills, and then tready drops until the output is taken.
module zero_cross_equal_power_crossfade_core
	import zcep_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// from_left, from_right, to_left, to_right
	input  logic [IN_DATA_BITS-1:0]   s_axis_tdata,
	// start_req
	input  logic                      s_axis_tuser,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// mix_left, mix_right
	output logic [OUT_DATA_BITS-1:0]  m_axis_tdata,
	output logic                      m_axis_tlast,
	// clipped
	output logic                      m_axis_tuser,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	logic [TABLE_BITS-1:0] rom_addr_a;
	logic [TABLE_BITS-1:0] rom_addr_b;
	logic [GAIN_BITS-1:0]  rom_data_a;
	logic [GAIN_BITS-1:0]  rom_data_b;
	logic                  mix_ready;
	zcep_stage_t           stage;

	// Registers accept every write in the cycle it is offered
	assign cfg_ready = 1'b1;

	zcep_gain_rom u_rom (
		.clk    (clk),
		.addr_a (rom_addr_a),
		.addr_b (rom_addr_b),
		.data_a (rom_data_a),
		.data_b (rom_data_b)
	);

	// Track position and phase, pick per-channel gains at sign crossings
	zcep_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tuser    (s_axis_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rom_addr_a (rom_addr_a),
		.rom_addr_b (rom_addr_b),
		.rom_data_a (rom_data_a),
		.rom_data_b (rom_data_b),
		.mix_ready  (mix_ready),
		.stage      (stage)
	);

	// Multiply, sum, truncate toward zero and saturate, or pass the incoming frame through after the fade; hold the result
	zcep_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.stage     (stage),
		.mix_ready (mix_ready),
		.m_tvalid  (m_axis_tvalid),
		.m_tready  (m_axis_tready),
		.m_tdata   (m_axis_tdata),
		.m_tlast   (m_axis_tlast),
		.m_tuser   (m_axis_tuser)
	);

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

// Checks the zero-crossing equal-power crossfade core. Each frame accepted on
// s_axis is run through a model of the fade kept in this bench; the mixed
// frames on m_axis must match it field by field and in order. Directed tests
// cover sample extremes, one-frame, zero-length and shrunk fades, zero and
// full-scale phase steps and clipping. Random fades with random lengths, steps
// and samples follow. Both stream sides idle at random.
module tb;
	import zcep_pkg::*;

	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_LO = CFG_INDEX_BITS'(2);
	localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_HI = CFG_INDEX_BITS'(3);
	localparam int ITEM_TARGET  = 1150;
	localparam int DRAIN_CYCLES = 6;
	localparam int REPORT_LIMIT = 10;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	localparam sample_t SMP_MIN = sample_t'(1 << (SAMPLE_BITS - 1));
	localparam sample_t SMP_MAX = ~SMP_MIN;

	typedef struct packed {
		logic    restart;
		sample_t to_r;
		sample_t to_l;
		sample_t from_r;
		sample_t from_l;
	} xfade_frame_t;

	typedef struct packed {
		logic    clip;
		logic    done;
		sample_t mix_r;
		sample_t mix_l;
	} mix_result_t;

	// Q30 coefficients of cos(pi/2*u) in powers of u^2, signs alternating
	localparam bit [63:0] COS_POLY_Q30 [8] = '{
		64'd1073741824, 64'd1324675879, 64'd272375562, 64'd22402022,
		64'd987047, 64'd27060, 64'd506, 64'd7
	};

	logic                      clk           = 1'b0;
	logic                      arst_n        = 1'b0;
	logic                      s_axis_tvalid = 1'b0;
	logic                      s_axis_tready;
	logic [IN_DATA_BITS-1:0]   s_axis_tdata  = '0;
	logic                      s_axis_tuser  = 1'b0;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0]  m_axis_tdata;
	logic                      m_axis_tlast;
	logic                      m_axis_tuser;
	logic                      cfg_valid     = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index     = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data      = '0;

	// Fade model state
	logic [GAIN_BITS-1:0]  gain_lut [TABLE_SIZE];
	logic [FRAME_BITS-1:0] len_frames;
	logic [PHASE_BITS-1:0] step_phase;
	logic [FRAME_BITS-1:0] fade_pos;
	logic [PHASE_BITS-1:0] fade_phase;
	logic [GAIN_BITS-1:0]  held_out [CHANNELS];
	logic [GAIN_BITS-1:0]  held_in [CHANNELS];
	logic                  prev_from [CHANNELS];
	logic                  prev_to [CHANNELS];
	logic                  signs_seeded;
	logic                  fade_over;

	mix_result_t expected_mix [$];

	bit          src_gaps    = 1'b0;
	bit          sink_stalls = 1'b0;
	int unsigned sink_hold   = 0;
	int unsigned frames_sent = 0;
	int unsigned mixes_seen  = 0;
	int unsigned regs_written = 0;
	int unsigned fades_done  = 0;
	int unsigned clips_seen  = 0;
	int unsigned mismatches  = 0;

	zero_cross_equal_power_crossfade_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// cos^2 table sampled at the middle of each of its steps, rounded to Q15
	function automatic void build_gain_lut();
		bit [63:0] u;
		bit [63:0] x;
		bit [63:0] c;
		bit [63:0] t;
		bit [63:0] g;
		for (int k = 0; k < TABLE_SIZE; k++) begin
			u = 64'(2 * k + 1) << (29 - TABLE_BITS);
			x = (u * u) >> 30;
			c = COS_POLY_Q30[7];
			for (int i = 6; i >= 0; i--) begin
				t = (c * x) >> 30;
				c = (COS_POLY_Q30[i] > t) ? COS_POLY_Q30[i] - t : 64'd0;
			end
			g = (c * c + (64'd1 << 44)) >> 45;
			gain_lut[k] = (g > 64'(Q15_ONE)) ? Q15_ONE : g[GAIN_BITS-1:0];
		end
	endfunction

	function automatic void clear_fade();
		fade_pos     = '0;
		fade_phase   = '0;
		signs_seeded = 1'b0;
		fade_over    = 1'b0;
		for (int j = 0; j < CHANNELS; j++) begin
			held_out[j]  = '0;
			held_in[j]   = '0;
			prev_from[j] = 1'b0;
			prev_to[j]   = 1'b0;
		end
	endfunction

	// Advance the fade by one frame and return the mixed frame it gives
	function automatic mix_result_t predict_mix(input xfade_frame_t f);
		mix_result_t          res;
		sample_t              from_s [CHANNELS];
		sample_t              to_s [CHANNELS];
		sample_t              mix_s [CHANNELS];
		logic [PHASE_BITS:0]  ph;
		logic [PHASE_BITS:0]  idx;
		logic [GAIN_BITS-1:0] nout;
		logic [GAIN_BITS-1:0] nin;
		longint               acc;
		logic                 sf;
		logic                 st;
		res       = '0;
		from_s[0] = f.from_l;
		from_s[1] = f.from_r;
		to_s[0]   = f.to_l;
		to_s[1]   = f.to_r;
		if (f.restart) begin
			clear_fade();
		end
		// Once the fade is over the incoming track passes straight through
		if (fade_over) begin
			res.mix_l = f.to_l;
			res.mix_r = f.to_r;
			return res;
		end
		ph  = {1'b0, fade_phase} + {1'b0, step_phase >> 1};
		idx = ph >> (PHASE_BITS - TABLE_BITS);
		if (idx >= TABLE_SIZE) begin
			idx = (PHASE_BITS + 1)'(TABLE_SIZE - 1);
		end
		nout = gain_lut[idx[TABLE_BITS-1:0]];
		nin  = Q15_ONE - nout;
		for (int j = 0; j < CHANNELS; j++) begin
			sf = !from_s[j][SAMPLE_BITS-1];
			st = !to_s[j][SAMPLE_BITS-1];
			if (held_out[j] == '0) begin
				held_out[j] = nout;
				held_in[j]  = nin;
			end
			if (!signs_seeded) begin
				prev_from[j] = sf;
				prev_to[j]   = st;
			end
			if (sf != prev_from[j]) begin
				held_out[j] = nout;
			end
			if (st != prev_to[j]) begin
				held_in[j] = nin;
			end
			prev_from[j] = sf;
			prev_to[j]   = st;
			acc = longint'(from_s[j]) * longint'({1'b0, held_out[j]})
				+ longint'(to_s[j]) * longint'({1'b0, held_in[j]});
			// signed division truncates toward zero, as the shift must
			acc = acc / (longint'(1) << GAIN_FRAC);
			if (acc > longint'(SMP_MAX)) begin
				acc      = longint'(SMP_MAX);
				res.clip = 1'b1;
			end else if (acc < longint'(SMP_MIN)) begin
				acc      = longint'(SMP_MIN);
				res.clip = 1'b1;
			end
			mix_s[j] = acc[SAMPLE_BITS-1:0];
		end
		signs_seeded = 1'b1;
		res.mix_l    = mix_s[0];
		res.mix_r    = mix_s[1];
		if ({1'b0, fade_pos} + 1'b1 >= {1'b0, len_frames}) begin
			fade_over = 1'b1;
			res.done  = 1'b1;
		end else begin
			fade_pos   = fade_pos + FRAME_BITS'(1);
			ph         = {1'b0, fade_phase} + {1'b0, step_phase};
			fade_phase = ph[PHASE_BITS] ? '1 : ph[PHASE_BITS-1:0];
		end
		return res;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return $urandom_range(1, 2);
		end else if (r < 95) begin
			return $urandom_range(3, 6);
		end
		return $urandom_range(20, 60);
	endfunction

	// Full-scale, near-zero (to force crossings) or extreme samples
	function automatic sample_t rand_sample();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			case ($urandom_range(0, 3))
				0: return SMP_MIN;
				1: return SMP_MAX;
				2: return sample_t'(0);
				default: return sample_t'(-1);
			endcase
		end else if (r < 55) begin
			return sample_t'(int'($urandom_range(0, 64)) - 32);
		end
		return sample_t'($urandom);
	endfunction

	function automatic void report_mismatch(input string what);
		mismatches++;
		if (mismatches <= REPORT_LIMIT) begin
			$display("tb: mismatch at %0t: %s", $realtime, what);
		end
	endfunction

	// Randomly stall the receiver, in runs of random length
	always @(posedge clk) begin
		if (sink_hold > 0) begin
			sink_hold--;
			m_axis_tready <= 1'b0;
		end else if (sink_stalls && $urandom_range(0, 99) < 20) begin
			sink_hold = pick_gap() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compare each mixed frame with the oldest one still owed
	always @(posedge clk) begin : check_mix
		mix_result_t want;
		mix_result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.mix_l = m_axis_tdata[SAMPLE_BITS-1:0];
			got.mix_r = m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
			got.done  = m_axis_tlast;
			got.clip  = m_axis_tuser;
			mixes_seen++;
			if (expected_mix.size() == 0) begin
				report_mismatch($sformatf("unexpected frame L %0d R %0d last %b clip %b",
					got.mix_l, got.mix_r, got.done, got.clip));
			end else begin
				want = expected_mix.pop_front();
				if (want.done) begin
					fades_done++;
				end
				if (want.clip) begin
					clips_seen++;
				end
				if (got !== want) begin
					report_mismatch($sformatf(
						"L %0d/%0d R %0d/%0d last %b/%b clip %b/%b (expected/actual)",
						want.mix_l, got.mix_l, want.mix_r, got.mix_r,
						want.done, got.done, want.clip, got.clip));
				end
			end
		end
	end

	// Present one frame, hold it until the handshake, then log what it owes
	task automatic send_frame(input logic restart, input sample_t fl, input sample_t fr,
		input sample_t tl, input sample_t tr);
		xfade_frame_t f;
		int unsigned  gap;
		f   = '{restart: restart, to_r: tr, to_l: tl, from_r: fr, from_l: fl};
		gap = (src_gaps && $urandom_range(0, 99) < 40) ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {f.to_r, f.to_l, f.from_r, f.from_l};
		s_axis_tuser  <= f.restart;
		do @(posedge clk); while (!s_axis_tready);
		expected_mix.push_back(predict_mix(f));
		frames_sent++;
	endtask

	// Drop valid and wait until the pipeline has given back every frame
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_mix.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
		input logic [CFG_DATA_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (index)
			REG_TOTAL_FRAMES: len_frames = value[FRAME_BITS-1:0];
			REG_PHASE_STEP:   step_phase = value;
			default: ;
		endcase
		regs_written++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic setup_fade(input logic [CFG_DATA_BITS-1:0] total,
		input logic [CFG_DATA_BITS-1:0] step);
		write_reg(REG_TOTAL_FRAMES, total);
		write_reg(REG_PHASE_STEP, step);
	endtask

	// Reset values of both registers; first frame seeds the signs
	task automatic test_reset_defaults();
		send_frame(1'b0, SMP_MAX, SMP_MIN, SMP_MIN, SMP_MAX);
		send_frame(1'b0, sample_t'(0), sample_t'(-1), sample_t'(1), sample_t'(0));
		send_frame(1'b1, SMP_MIN, SMP_MIN, SMP_MAX, SMP_MAX);
		send_frame(1'b0, sample_t'(-1), sample_t'(1), sample_t'(-1), sample_t'(1));
	endtask

	// One-frame fade at full-scale step, then pass-through, then a restart
	task automatic test_one_frame_fade();
		drain();
		setup_fade(1, '1);
		send_frame(1'b1, SMP_MAX, SMP_MAX, SMP_MIN, SMP_MIN);
		send_frame(1'b0, sample_t'(100), sample_t'(-100), SMP_MIN, SMP_MAX);
		send_frame(1'b1, sample_t'(-5), sample_t'(5), sample_t'(7), sample_t'(-7));
	endtask

	// Zero length ends on the first frame; zero step holds the first entry
	task automatic test_zero_settings();
		drain();
		setup_fade(0, 0);
		send_frame(1'b1, SMP_MIN, SMP_MAX, sample_t'(1234), sample_t'(-1234));
		drain();
		write_reg(REG_TOTAL_FRAMES, 3);
		send_frame(1'b1, sample_t'(2000), sample_t'(-2000), sample_t'(-3), sample_t'(3));
		send_frame(1'b0, sample_t'(-2000), sample_t'(2000), sample_t'(3), sample_t'(-3));
	endtask

	// Gains move only on sign changes; a stale out gain with a fresh in gain
	// pushes the sum past full scale and clips
	task automatic test_sign_crossings();
		drain();
		setup_fade(8, 32'h2000_0000);
		send_frame(1'b1, SMP_MIN, sample_t'(300), sample_t'(1000), sample_t'(-200));
		send_frame(1'b0, SMP_MIN, sample_t'(-300), sample_t'(500), sample_t'(200));
		send_frame(1'b0, SMP_MIN, sample_t'(0), sample_t'(800), sample_t'(-1));
		send_frame(1'b0, SMP_MIN, sample_t'(-1), sample_t'(1), sample_t'(0));
		send_frame(1'b0, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX);
		send_frame(1'b0, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN);
	endtask

	// Saturating phase; a length written below the position ends the fade
	task automatic test_shrunk_length();
		drain();
		setup_fade(20, '1);
		send_frame(1'b1, sample_t'(9000), sample_t'(-9000), sample_t'(-9000), sample_t'(9000));
		send_frame(1'b0, sample_t'(-9000), sample_t'(9000), sample_t'(9000), sample_t'(-9000));
		send_frame(1'b0, sample_t'(50), sample_t'(-50), sample_t'(-50), sample_t'(50));
		send_frame(1'b0, sample_t'(-50), sample_t'(50), sample_t'(50), sample_t'(-50));
		drain();
		// unused indexes must leave both registers alone
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, 32'h0000_0001);
		write_reg(REG_TOTAL_FRAMES, 2);
		send_frame(1'b0, sample_t'(77), sample_t'(-77), sample_t'(-88), sample_t'(88));
		send_frame(1'b0, sample_t'(77), sample_t'(-77), sample_t'(-88), sample_t'(88));
	endtask

	// Longest length with junk in the unused upper data bits, smallest nonzero step
	task automatic test_max_length();
		drain();
		setup_fade({8'hA5, 24'hFF_FFFF}, 1);
		send_frame(1'b1, SMP_MAX, SMP_MIN, SMP_MAX, SMP_MIN);
		send_frame(1'b0, SMP_MIN, SMP_MAX, SMP_MIN, SMP_MAX);
	endtask

	// Random fades: mostly short lengths that run to the end and on into
	// pass-through, with stray restarts and fresh settings for each fade
	task automatic test_random_fades();
		int unsigned r;
		int unsigned span;
		logic [23:0] total;
		logic [32:0] even_step;
		logic [31:0] step;
		logic        restart;
		while (frames_sent < ITEM_TARGET) begin
			drain();
			r = $urandom_range(0, 99);
			if (r < 65) begin
				total = 24'($urandom_range(1, 40));
			end else if (r < 90) begin
				total = 24'($urandom_range(41, 300));
			end else begin
				total = 24'($urandom_range(301, 24'hFF_FFFF));
			end
			r = $urandom_range(0, 99);
			if (r < 60) begin
				even_step = 33'h1_0000_0000 / total;
				step      = even_step[32] ? '1 : even_step[31:0];
			end else if (r < 85) begin
				step = $urandom;
			end else begin
				step = $urandom_range(0, 4095);
			end
			setup_fade({8'($urandom), total}, step);
			src_gaps    = $urandom_range(0, 2) != 0;
			sink_stalls = $urandom_range(0, 2) != 0;
			span        = $urandom_range(30, 110);
			for (int n = 0; n < span; n++) begin
				if (n == 0) begin
					restart = $urandom_range(0, 9) != 0;
				end else if (fade_over) begin
					restart = $urandom_range(0, 3) == 0;
				end else begin
					restart = $urandom_range(0, 49) == 0;
				end
				send_frame(restart, rand_sample(), rand_sample(), rand_sample(),
					rand_sample());
			end
		end
	endtask

	initial begin
		build_gain_lut();
		clear_fade();
		len_frames = TOTAL_RESET;
		step_phase = STEP_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		test_reset_defaults();
		test_one_frame_fade();
		test_zero_settings();
		test_sign_crossings();
		test_shrunk_length();
		test_max_length();
		test_random_fades();
		drain();
		$display("tb: %0d frames sent, %0d mixed frames checked, %0d register writes",
			frames_sent, mixes_seen, regs_written);
		$display("tb: %0d fades reached their last frame, %0d frames clipped, %0d mismatches",
			fades_done, clips_seen, mismatches);
		if (mismatches == 0 && expected_mix.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest correct run
	initial begin
		#20_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/zcep_pkg.sv
rtl/zcep_gain_rom.sv
rtl/zcep_ctrl.sv
rtl/zcep_mix.sv
rtl/zero_cross_equal_power_crossfade_core.sv
sim/tb.sv
